@@ rtl/core/nfcrp_pkg.sv @@
// ----------------------------------------------------------------------------
// NFC response frame parser package
// Shared constants, status codes and the result record type.
// ----------------------------------------------------------------------------
package nfcrp_pkg;

  // Frame layout
  localparam int unsigned FrameBytesDefault = 32;
  localparam int unsigned PayloadStart      = 8;
  localparam int unsigned PayloadMax        = 24;
  localparam int unsigned PosMax            = 63;

  // Header byte values
  localparam logic [7:0] ReadyByte   = 8'h01;
  localparam logic [7:0] PreambleLow = 8'h00;
  localparam logic [7:0] PreambleEnd = 8'hFF;
  localparam logic [7:0] DirToHost   = 8'hD5;

  // Configuration register indexes
  localparam logic [7:0] RegExpectedCommand = 8'd0;
  localparam logic [7:0] RegPayloadLimit    = 8'd1;

  // Result queue depth
  localparam int unsigned ResultDepth = 4;

  // Result kind carried in tuser
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_READY  = 3'd1,
    ST_PREAMBLE   = 3'd2,
    ST_LEN_SUM    = 3'd3,
    ST_TOO_SHORT  = 3'd4,
    ST_DIRECTION  = 3'd5,
    ST_RESPONSE   = 3'd6,
    ST_SHORT_READ = 3'd7
  } status_t;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    status_t    status;
    logic [4:0] length;
    logic       last;
  } result_t;

  // Push request into the result queue; second slot only used with the first
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

@@ rtl/core/nfcrp_result_fifo.sv @@
// ----------------------------------------------------------------------------
// NFC response frame parser result queue
// Small queue that takes up to two results per cycle and delivers one.
// ----------------------------------------------------------------------------
module nfcrp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  nfcrp_pkg::push_t   push,
  input  nfcrp_pkg::result_t data0,
  input  nfcrp_pkg::result_t data1,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output nfcrp_pkg::result_t out_data
);

  localparam int unsigned PtrW = $clog2(nfcrp_pkg::ResultDepth);
  localparam int unsigned CntW = $clog2(nfcrp_pkg::ResultDepth + 1);

  nfcrp_pkg::result_t entries [nfcrp_pkg::ResultDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;
  logic [CntW-1:0] count_next;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  // Room for the worst case of two results from one transaction.
  assign has_room  = (count <= CntW'(nfcrp_pkg::ResultDepth - 2));

  always_comb begin
    count_next = count + CntW'(push.push0) + CntW'(push.push1) - CntW'(pop);
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.push0) begin
      entries[wr_ptr] <= data0;
    end
    if (push.push1) begin
      entries[wr_ptr + PtrW'(1)] <= data1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.push0) + PtrW'(push.push1);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

endmodule

@@ rtl/core/nfc_response_frame_parser.sv @@
// ----------------------------------------------------------------------------
// NFC response frame parser
// Checks the header of one fixed-size controller read and streams out the
// payload bytes followed by a status result.
//
// The parser takes one byte per clock cycle and sustains that rate: each
// byte is checked by a single level of logic against the frame position and
// its results go straight into a four-entry result queue. A byte that is the
// last payload byte and also ends the read yields two results, so the queue
// drains one behind for that frame; input tready drops only when the queue
// holds more than two results, that is when the output side stalls. Results
// are registered in the result queue before they reach the output. The first failing
// header check is reported; payload bytes are sent only while no check has
// failed, and state returns to its reset values after each status result.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser #(
  parameter int unsigned FRAME_BYTES = nfcrp_pkg::FrameBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // end_of_read
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status_code,
                                      // [15:11] payload_length
  output logic        m_axis_tuser,   // item_kind
  output logic        m_axis_tlast,   // last_result
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Frame position compares use one extra bit so a 64-byte frame fits.
  localparam logic [6:0] FrameLen = 7'(FRAME_BYTES);

  // Configuration registers
  logic [7:0] expected_command;
  logic [4:0] payload_limit;

  // Frame state
  logic [5:0]         byte_position;
  logic [7:0]         frame_length;
  nfcrp_pkg::status_t error_seen;
  logic [4:0]         payload_count;

  logic [5:0]         byte_position_next;
  logic [7:0]         frame_length_next;
  nfcrp_pkg::status_t error_seen_next;
  logic [4:0]         payload_count_next;

  logic               in_fire;
  logic               fifo_room;
  logic               in_frame;
  logic               short_read;
  logic               emit_payload;
  nfcrp_pkg::status_t check_code;
  nfcrp_pkg::status_t error_after;
  nfcrp_pkg::status_t final_status;
  logic [4:0]         limit_eff;
  logic [7:0]         avail;
  logic [4:0]         target;
  logic [7:0]         rx_byte;

  nfcrp_pkg::push_t   push;
  nfcrp_pkg::result_t pay_res;
  nfcrp_pkg::result_t stat_res;
  nfcrp_pkg::result_t slot0;
  nfcrp_pkg::result_t head;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = fifo_room;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= 8'd0;
      payload_limit    <= 5'(nfcrp_pkg::PayloadMax);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nfcrp_pkg::RegExpectedCommand: expected_command <= cfg_data;
        nfcrp_pkg::RegPayloadLimit:    payload_limit    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Payload budget: min(length - 2, limit), limit capped at the maximum.
  always_comb begin
    limit_eff = (payload_limit > 5'(nfcrp_pkg::PayloadMax)) ?
                5'(nfcrp_pkg::PayloadMax) : payload_limit;
    avail     = (frame_length >= 8'd2) ? (frame_length - 8'd2) : 8'd0;
    target    = (avail < {3'b000, limit_eff}) ? avail[4:0] : limit_eff;
  end

  // Header check for the byte at the current position.
  always_comb begin
    in_frame          = ({1'b0, byte_position} < FrameLen);
    short_read        = (({1'b0, byte_position} + 7'd1) < FrameLen);
    check_code        = nfcrp_pkg::ST_OK;
    frame_length_next = frame_length;
    emit_payload      = 1'b0;
    if (in_frame) begin
      case (byte_position)
        6'd0: begin
          if (rx_byte != nfcrp_pkg::ReadyByte) check_code = nfcrp_pkg::ST_NOT_READY;
        end
        6'd1, 6'd2: begin
          if (rx_byte != nfcrp_pkg::PreambleLow) check_code = nfcrp_pkg::ST_PREAMBLE;
        end
        6'd3: begin
          if (rx_byte != nfcrp_pkg::PreambleEnd) check_code = nfcrp_pkg::ST_PREAMBLE;
        end
        6'd4: begin
          frame_length_next = rx_byte;
        end
        6'd5: begin
          if ((frame_length + rx_byte) != 8'd0) begin
            check_code = nfcrp_pkg::ST_LEN_SUM;
          end else if (frame_length < 8'd2) begin
            check_code = nfcrp_pkg::ST_TOO_SHORT;
          end
        end
        6'd6: begin
          if (rx_byte != nfcrp_pkg::DirToHost) check_code = nfcrp_pkg::ST_DIRECTION;
        end
        6'd7: begin
          if (rx_byte != (expected_command + 8'd1)) check_code = nfcrp_pkg::ST_RESPONSE;
        end
        default: begin
          emit_payload = (error_seen == nfcrp_pkg::ST_OK) && (payload_count < target);
        end
      endcase
    end
  end

  // Next frame state; the first failure is kept.
  always_comb begin
    error_after        = (error_seen != nfcrp_pkg::ST_OK) ? error_seen : check_code;
    final_status       = (error_after == nfcrp_pkg::ST_OK && short_read) ?
                         nfcrp_pkg::ST_SHORT_READ : error_after;
    payload_count_next = payload_count + 5'(emit_payload);
    if (s_axis_tlast) begin
      byte_position_next = 6'd0;
      error_seen_next    = nfcrp_pkg::ST_OK;
    end else begin
      byte_position_next = (byte_position < 6'(nfcrp_pkg::PosMax)) ?
                           (byte_position + 6'd1) : byte_position;
      error_seen_next    = error_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 6'd0;
      frame_length  <= 8'd0;
      error_seen    <= nfcrp_pkg::ST_OK;
      payload_count <= 5'd0;
    end else if (in_fire) begin
      byte_position <= byte_position_next;
      error_seen    <= error_seen_next;
      frame_length  <= s_axis_tlast ? 8'd0 : frame_length_next;
      payload_count <= s_axis_tlast ? 5'd0 : payload_count_next;
    end
  end

  // Result records for this transaction.
  always_comb begin
    pay_res.kind    = nfcrp_pkg::KindPayload;
    pay_res.data    = rx_byte;
    pay_res.status  = nfcrp_pkg::ST_OK;
    pay_res.length  = 5'd0;
    pay_res.last    = 1'b0;

    stat_res.kind   = nfcrp_pkg::KindStatus;
    stat_res.data   = 8'd0;
    stat_res.status = final_status;
    stat_res.length = (final_status == nfcrp_pkg::ST_OK) ? payload_count_next : 5'd0;
    stat_res.last   = 1'b1;

    slot0      = emit_payload ? pay_res : stat_res;
    push.push0 = in_fire && (emit_payload || s_axis_tlast);
    push.push1 = in_fire && emit_payload && s_axis_tlast;
  end

  nfcrp_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data0     (slot0),
    .data1     (stat_res),
    .has_room  (fifo_room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  assign m_axis_tdata = {head.length, head.status, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // A status result always closes the frame, and payload results never do.
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
    else $error("status kind and last flag disagree");

  // The byte that ends a read leaves the parser at the frame start.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tlast) |=> (byte_position == 6'd0 && payload_count == 5'd0))
    else $error("frame state not cleared after end of read");

  // Payload delivery never exceeds the largest allowed payload.
  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    payload_count <= 5'(nfcrp_pkg::PayloadMax))
    else $error("payload count beyond maximum");

  // No payload result is produced after a header failure was recorded.
  a_no_payload_after_error: assert property (@(posedge clk) disable iff (rst)
    (error_seen != nfcrp_pkg::ST_OK) |-> !emit_payload)
    else $error("payload emitted after header failure");

endmodule
